FILE: rtl/touch_zone_button_mapper_core_macros.svh
// assertion macros for the touch zone button mapper
// no dependencies
`ifndef TOUCH_ZONE_BUTTON_MAPPER_CORE_MACROS_SVH
`define TOUCH_ZONE_BUTTON_MAPPER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TZBM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TZBM_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TZBM_ASSERT(label, clk, rst, prop, msg)
`define TZBM_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: rtl/tzbm_pkg.sv
// shared types, constants and zone tables for the touch zone button mapper
// no dependencies
`default_nettype none
package tzbm_pkg;
   localparam int unsigned LAYOUT_W = 1024;
   localparam int unsigned LAYOUT_H = 768;
   localparam int unsigned GAME_ZONES = 15;
   localparam int unsigned MENU_ZONES = 4;
   localparam logic [4:0] MENU_ZONE_IDX = 5'd14;
   localparam logic [4:0] NO_KEY = 5'd16;

   typedef enum logic [1:0] {
      OP_DOWN = 2'd0, OP_UP = 2'd1, OP_MOTION = 2'd2, OP_POLL = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IGNORED = 2'd0, ST_CONSUMED = 2'd1, ST_MENU_REQ = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CSR_WIDTH = 3'd0, CSR_HEIGHT = 3'd1, CSR_MODE = 3'd2,
      CSR_DEBOUNCE = 3'd3, CSR_ENABLE = 3'd4
   } csr_idx_type;

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_HIT, S_SCAN, S_OUT
   } state_type;

   typedef struct packed {
      logic [3:0] addr;
      logic       wr_en;
      logic [4:0] wr_data;
   } mem_req_type;

   // ends are exclusive
   typedef struct packed {
      logic [10:0] x;
      logic [10:0] y;
      logic [10:0] x_end;
      logic [10:0] y_end;
      logic [4:0]  key;
   } zone_type;

   // entry code in finger memory: bit4 valid, low bits zone index
   function automatic zone_type game_zone(input logic [3:0] i);
      zone_type z;
      case (i)
         4'd0:    z = '{11'd80, 11'd456, 11'd160, 11'd536, 5'd4};
         4'd1:    z = '{11'd80, 11'd616, 11'd160, 11'd696, 5'd6};
         4'd2:    z = '{11'd0, 11'd536, 11'd80, 11'd616, 5'd7};
         4'd3:    z = '{11'd160, 11'd536, 11'd240, 11'd616, 5'd5};
         4'd4:    z = '{11'd864, 11'd456, 11'd944, 11'd536, 5'd12};
         4'd5:    z = '{11'd864, 11'd616, 11'd944, 11'd696, 5'd14};
         4'd6:    z = '{11'd784, 11'd536, 11'd864, 11'd616, 5'd15};
         4'd7:    z = '{11'd944, 11'd536, 11'd1024, 11'd616, 5'd13};
         4'd8:    z = '{11'd0, 11'd154, 11'd120, 11'd214, 5'd10};
         4'd9:    z = '{11'd0, 11'd214, 11'd120, 11'd274, 5'd8};
         4'd10:   z = '{11'd904, 11'd154, 11'd1024, 11'd214, 5'd11};
         4'd11:   z = '{11'd904, 11'd214, 11'd1024, 11'd274, 5'd9};
         4'd12:   z = '{11'd400, 11'd708, 11'd500, 11'd768, 5'd0};
         4'd13:   z = '{11'd524, 11'd708, 11'd624, 11'd768, 5'd3};
         4'd14:   z = '{11'd462, 11'd0, 11'd562, 11'd50, NO_KEY};
         default: z = '{11'd0, 11'd0, 11'd0, 11'd0, NO_KEY};
      endcase
      return z;
   endfunction

   function automatic zone_type menu_zone(input logic [1:0] i);
      zone_type z;
      case (i)
         2'd0:    z = '{11'd50, 11'd570, 11'd170, 11'd660, 5'd0};
         2'd1:    z = '{11'd190, 11'd570, 11'd310, 11'd660, 5'd1};
         2'd2:    z = '{11'd714, 11'd570, 11'd834, 11'd660, 5'd2};
         default: z = '{11'd854, 11'd570, 11'd974, 11'd660, 5'd3};
      endcase
      return z;
   endfunction
endpackage
`default_nettype wire

FILE: rtl/tzbm_if.sv
// valid/ready channel interfaces for requests and responses
// depends on nothing
`default_nettype none
interface tzbm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [7:0]  finger;
   logic [11:0] pos_x;
   logic [11:0] pos_y;
   logic        contact_held;
   logic [31:0] now_ms;
   modport source (output valid, op, finger, pos_x, pos_y, contact_held, now_ms,
                   input ready);
   modport sink (input valid, op, finger, pos_x, pos_y, contact_held, now_ms,
                 output ready);
endinterface

interface tzbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_status;
   logic [15:0] pad_mask;
   logic [3:0]  menu_held;
   logic [3:0]  menu_fired;
   modport source (output valid, event_status, pad_mask, menu_held, menu_fired,
                   input ready);
   modport sink (input valid, event_status, pad_mask, menu_held, menu_fired,
                 output ready);
endinterface
`default_nettype wire

FILE: rtl/tzbm_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on tzbm_pkg
`default_nettype none
module tzbm_div
   import tzbm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [21:0] dividend,
   input  wire logic [12:0] divisor,
   output logic             done,
   output logic [21:0]      quotient
);
   logic [21:0] q_ff, q_in;
   logic [13:0] r_ff, r_in;
   logic [12:0] d_ff, d_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [13:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {r_ff[12:0], q_ff[21]};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         d_in = (divisor == '0) ? 13'd1 : divisor;
         cnt_in = 5'd21;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[20:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[20:0], 1'b0};
         end
         if (cnt_ff == '0) busy_in = 1'b0;
         else cnt_in = cnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   // final quotient while done, independent of a new start in the same cycle
   assign done = busy_ff && (cnt_ff == '0);
   assign quotient = {q_ff[20:0], (trial >= {1'b0, d_ff})};
endmodule
`default_nettype wire

FILE: rtl/tzbm_finger_mem.sv
// finger zone memory with clear-epoch tags, read back by the core's mask rebuild scan
// depends on tzbm_pkg
`default_nettype none
module tzbm_finger_mem
   import tzbm_pkg::*;
#(
   parameter int unsigned FINGER_COUNT = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        clear,
   input  wire mem_req_type req,
   output logic [4:0]       rd_data
);
   // entry: {epoch, valid, zone[3:0]}; stale epoch reads as none
   logic [5:0] mem [FINGER_COUNT];
   logic [5:0] rd_ff;
   logic       epoch_ff;
   logic [FINGER_COUNT-1:0] seen_ff;
   logic [3:0] rd_addr_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) mem[req.addr] <= {epoch_ff, req.wr_data};
      rd_ff <= mem[req.addr];
      rd_addr_ff <= req.addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff <= 1'b0;
         seen_ff <= '0;
      end else if (clear) begin
         epoch_ff <= ~epoch_ff;
         seen_ff <= '0;
      end else if (req.wr_en) begin
         seen_ff[req.addr] <= 1'b1;
      end
   end

   assign rd_data = (seen_ff[rd_addr_ff] && rd_ff[5] == epoch_ff) ? rd_ff[4:0] : 5'd0;
endmodule
`default_nettype wire

FILE: rtl/touch_zone_button_mapper_core.sv
// touch zone button mapper: zone hit test, finger memory, mask and poll logic
// depends on tzbm_pkg, tzbm_if, tzbm_div, tzbm_finger_mem and the macro header
//
// usage: request beats on req carry op, finger, position, contact flag and time;
// each request yields exactly one response beat on rsp. csr writes (enable,
// index, data) take effect at once and are to be issued only while the block is
// idle; the block itself does not enforce this. a poll, an ignored beat or a
// motion without contact goes straight to the output; an up runs the finger
// memory scan; a down or motion with contact first runs two serial divides for
// x and y scaling, then the hit test and the scan; a down that misses every zone
// skips the finger write, one on the menu zone skips the scan. one request is in
// flight at a time and req.ready returns in the cycle after the response beat;
// the finger memory scan reads one entry per cycle through a single read port.
// the response sits in an output register; req.ready stays low until the
// response beat is taken, so a stalled receiver holds the block.
// reset clears all masks, fingers (per-entry seen bits, no sweep) and the
// debounce state, and loads the csr reset values.
`default_nettype none
`include "touch_zone_button_mapper_core_macros.svh"
module touch_zone_button_mapper_core
   import tzbm_pkg::*;
#(
   parameter int unsigned FINGER_COUNT = 10
) (
   input  wire logic   clock,
   input  wire logic   reset,
   tzbm_req_if.sink    req,
   tzbm_rsp_if.source  rsp,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   logic [12:0] width_ff, height_ff;
   logic        mode_ff, en_ff;
   logic [15:0] deb_ff;
   logic        clear;

   state_type   state_ff, state_in;
   logic [1:0]  op_ff;
   logic [3:0]  fing_ff;
   logic [11:0] py_ff;
   logic [31:0] now_ff;
   logic        phase_ff, phase_in;
   logic [10:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [4:0]  scan_ff, scan_in;
   logic        rd_pend_ff, rd_pend_in;
   logic [15:0] pad_acc_ff, pad_acc_in;
   logic [3:0]  menu_acc_ff, menu_acc_in;
   logic [15:0] pad_ff;
   logic [3:0]  menu_ff;
   logic [31:0] last_ff [4];
   logic [3:0]  prev_ff;
   logic [1:0]  stat_ff, stat_in;
   logic        rv_ff;
   logic [3:0]  fired_ff;
   logic        do_write_ff, do_write_in;
   logic [4:0]  wr_code_ff, wr_code_in;

   logic        div_start, div_done;
   logic [21:0] div_q, dividend;
   logic [12:0] divisor;
   mem_req_type mreq;
   logic [4:0]  rd_data;
   logic [4:0]  hit;
   logic        accept;
   logic [3:0]  fired_c;
   zone_type    gz;
   zone_type    mz;
   zone_type    rz;

   assign clear = csr_we && (((csr_index == CSR_MODE) && (csr_wdata[0] != mode_ff))
                  || ((csr_index == CSR_ENABLE) && csr_wdata[0] && !en_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 13'd1024;
         height_ff <= 13'd768;
         mode_ff <= 1'b0;
         deb_ff <= 16'd250;
         en_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:    width_ff <= csr_wdata[12:0];
            CSR_HEIGHT:   height_ff <= csr_wdata[12:0];
            CSR_MODE:     mode_ff <= csr_wdata[0];
            CSR_DEBOUNCE: deb_ff <= csr_wdata;
            CSR_ENABLE:   en_ff <= csr_wdata[0];
            default:      ;
         endcase
      end
   end

   assign accept = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE) && !rv_ff;

   // one divider shared between x (started from idle) and y (started in S_DIV)
   assign dividend = (state_ff == S_IDLE) ? {req.pos_x, 10'd0}
                                          : ({10'd0, py_ff} * 22'd768);
   assign divisor  = (state_ff == S_IDLE) ? width_ff : height_ff;

   tzbm_div u_div (
      .clock, .reset,
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   tzbm_finger_mem #(.FINGER_COUNT(FINGER_COUNT)) u_mem (
      .clock, .reset,
      .clear   (clear),
      .req     (mreq),
      .rd_data (rd_data)
   );

   // hit test over all zones of the current table in parallel
   always_comb begin
      hit = 5'd31;
      mz = menu_zone(2'd0);
      gz = game_zone(4'd0);
      if (mode_ff) begin
         for (int i = MENU_ZONES - 1; i >= 0; i--) begin
            mz = menu_zone(2'(i));
            if (sx_ff >= mz.x && sx_ff < mz.x_end && sy_ff >= mz.y && sy_ff < mz.y_end)
               hit = 5'(i);
         end
      end else begin
         for (int i = GAME_ZONES - 1; i >= 0; i--) begin
            gz = game_zone(4'(i));
            if (sx_ff >= gz.x && sx_ff < gz.x_end && sy_ff >= gz.y && sy_ff < gz.y_end)
               hit = 5'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++)
         fired_c[i] = menu_ff[i] && !prev_ff[i] && ((now_ff - last_ff[i]) >= {16'd0, deb_ff});
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      sx_in = sx_ff;
      sy_in = sy_ff;
      scan_in = scan_ff;
      rd_pend_in = 1'b0;
      pad_acc_in = pad_acc_ff;
      menu_acc_in = menu_acc_ff;
      stat_in = stat_ff;
      do_write_in = do_write_ff;
      wr_code_in = wr_code_ff;
      div_start = 1'b0;
      rz = game_zone(rd_data[3:0]);
      mreq = '{addr: scan_ff[3:0], wr_en: 1'b0, wr_data: wr_code_ff};
      case (state_ff)
         S_IDLE: if (accept) begin
            stat_in = ST_IGNORED;
            do_write_in = 1'b0;
            wr_code_in = 5'd0;
            phase_in = 1'b0;
            if (req.op == OP_POLL) state_in = S_OUT;
            else if (!en_ff) state_in = S_OUT;
            else begin
               stat_in = ST_CONSUMED;
               if (req.op == OP_UP) begin
                  do_write_in = 1'b1;
                  state_in = S_SCAN;
                  scan_in = 5'd31;
               end else if (req.op == OP_MOTION && !req.contact_held) begin
                  state_in = S_OUT;
               end else begin
                  div_start = 1'b1;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: if (div_done) begin
            // anything past the layout edge misses every zone
            if (!phase_ff) begin
               sx_in = (div_q > 22'd1023) ? 11'd1024 : div_q[10:0];
               phase_in = 1'b1;
               div_start = 1'b1;
            end else begin
               sy_in = (div_q > 22'd1023) ? 11'd1024 : div_q[10:0];
               state_in = S_HIT;
            end
         end
         S_HIT: begin
            state_in = S_SCAN;
            scan_in = 5'd31;
            if (hit == 5'd31) begin
               do_write_in = (op_ff == OP_MOTION);
               wr_code_in = 5'd0;
            end else if (!mode_ff && hit == MENU_ZONE_IDX && op_ff == OP_DOWN) begin
               stat_in = ST_MENU_REQ;
               state_in = S_OUT;
            end else begin
               do_write_in = 1'b1;
               wr_code_in = {1'b1, hit[3:0]};
            end
         end
         S_SCAN: begin
            // first step writes the finger, then reads every entry back; with no write due it goes to S_OUT
            if (scan_ff == 5'd31) begin
               mreq.addr = fing_ff;
               mreq.wr_en = do_write_ff;
               pad_acc_in = '0;
               menu_acc_in = '0;
               scan_in = '0;
               state_in = do_write_ff ? S_SCAN : S_OUT;
               rd_pend_in = 1'b0;
            end else begin
               mreq.addr = scan_ff[3:0];
               rd_pend_in = (scan_ff < 5'(FINGER_COUNT));
               if (scan_ff < 5'(FINGER_COUNT)) scan_in = scan_ff + 5'd1;
               if (!rd_pend_in && !rd_pend_ff) state_in = S_OUT;
            end
            if (rd_pend_ff && rd_data[4]) begin
               if (mode_ff) menu_acc_in[rd_data[1:0]] = 1'b1;
               else if (rz.key != NO_KEY) pad_acc_in[rz.key[3:0]] = 1'b1;
            end
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req.op;
         fing_ff <= (req.finger >= 8'(FINGER_COUNT)) ? 4'd0 : req.finger[3:0];
         py_ff <= req.pos_y;
         now_ff <= req.now_ms;
      end
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      scan_ff <= scan_in;
      pad_acc_ff <= pad_acc_in;
      menu_acc_ff <= menu_acc_in;
      stat_ff <= stat_in;
      wr_code_ff <= wr_code_in;
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
         do_write_ff <= 1'b0;
         rv_ff <= 1'b0;
         pad_ff <= '0;
         menu_ff <= '0;
         prev_ff <= '0;
         fired_ff <= '0;
         for (int i = 0; i < 4; i++) last_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         rd_pend_ff <= rd_pend_in;
         do_write_ff <= do_write_in;
         if (clear) begin
            pad_ff <= '0;
            menu_ff <= '0;
            prev_ff <= '0;
            for (int i = 0; i < 4; i++) last_ff[i] <= '0;
         end else if (state_ff == S_SCAN && state_in == S_OUT && do_write_ff) begin
            pad_ff <= pad_acc_in;
            menu_ff <= menu_acc_in;
         end
         if (state_ff == S_OUT) begin
            rv_ff <= 1'b1;
            fired_ff <= (op_ff == OP_POLL) ? fired_c : 4'd0;
            if (op_ff == OP_POLL) begin
               prev_ff <= menu_ff;
               for (int i = 0; i < 4; i++) if (fired_c[i]) last_ff[i] <= now_ff;
            end
         end else if (rv_ff && rsp.ready) begin
            rv_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid = rv_ff;
   assign rsp.event_status = stat_ff;
   assign rsp.pad_mask = pad_ff;
   assign rsp.menu_held = menu_ff;
   assign rsp.menu_fired = fired_ff;

   `TZBM_ASSERT(a_no_accept_busy, clock, reset, accept |-> state_ff == S_IDLE && !rv_ff, "accept while busy")
   `TZBM_ASSERT(a_one_mask, clock, reset, rv_ff |-> !(mode_ff && pad_ff != '0), "pad bits in menu mode")
   `TZBM_ASSERT(a_poll_status, clock, reset, (rv_ff && op_ff == OP_POLL) |-> stat_ff == ST_IGNORED, "poll status")
   `TZBM_ASSERT(a_fired_poll, clock, reset, (rv_ff && op_ff != OP_POLL) |-> fired_ff == '0, "fired on non-poll")
endmodule
`default_nettype wire
